FILE: hw/rtl/lmsr_pkg.sv
// ----------------------------------------------------------------------------
// lmsr_pkg
// Types and constants shared by the LED matrix scroll and refresh unit.
// ----------------------------------------------------------------------------
package lmsr_pkg;

	localparam int ROWS     = 8;
	localparam int XFER_W   = 3;
	localparam int DEVICE_W = 3;

	localparam logic [3:0] ACT_INIT      = 4'd0;
	localparam logic [3:0] ACT_INTENSITY = 4'd1;
	localparam logic [3:0] ACT_WRITE     = 4'd2;
	localparam logic [3:0] ACT_SHL       = 4'd3;
	localparam logic [3:0] ACT_SHR       = 4'd4;
	localparam logic [3:0] ACT_ROL       = 4'd5;
	localparam logic [3:0] ACT_ROR       = 4'd6;
	localparam logic [3:0] ACT_CLEAR     = 4'd7;
	localparam logic [3:0] ACT_FILL      = 4'd8;
	localparam logic [3:0] ACT_REFRESH   = 4'd9;

	localparam logic [3:0] ADDR_DECODE    = 4'd9;
	localparam logic [3:0] ADDR_INTENSITY = 4'd10;
	localparam logic [3:0] ADDR_SCAN      = 4'd11;
	localparam logic [3:0] ADDR_SHUTDOWN  = 4'd12;

	localparam logic [7:0] SCAN_ALL_ROWS = 8'd7;
	localparam logic [7:0] BYTE_FULL     = 8'hff;
	localparam logic [3:0] BRIGHT_RESET  = 4'd5;

	localparam logic [XFER_W-1:0] XFER_SHUTDOWN = 3'd0;
	localparam logic [XFER_W-1:0] XFER_DECODE   = 3'd1;
	localparam logic [XFER_W-1:0] XFER_SCAN     = 3'd2;
	localparam logic [XFER_W-1:0] XFER_WAKE     = 3'd3;
	localparam logic [XFER_W-1:0] XFER_INIT_END = 3'd4;
	localparam logic [XFER_W-1:0] XFER_ONE_END  = 3'd0;
	localparam logic [XFER_W-1:0] XFER_ROWS_END = 3'd7;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		KIND_INIT,
		KIND_INTENSITY,
		KIND_REFRESH
	} kind_t;

	typedef enum logic [2:0] {
		BUF_NONE,
		BUF_WRITE,
		BUF_SHL,
		BUF_SHR,
		BUF_ROL,
		BUF_ROR,
		BUF_CLEAR,
		BUF_FILL
	} buf_op_t;

	typedef struct packed {
		buf_op_t     op;
		logic [2:0]  matrix;
		logic [2:0]  row;
		logic [7:0]  data;
	} buf_cmd_t;

	typedef struct packed {
		logic                load;
		kind_t               kind;
		logic [XFER_W-1:0]   xfer;
		logic [DEVICE_W-1:0] device;
		logic                last;
	} emit_cmd_t;

	typedef struct packed {
		logic out_valid;
	} dp_status_t;

endpackage

FILE: hw/rtl/lmsr_ctrl.sv
// ----------------------------------------------------------------------------
// lmsr_ctrl
// Command decode and frame sequencer: walks transfers and devices.
// ----------------------------------------------------------------------------
module lmsr_ctrl import lmsr_pkg::*; #(
	parameter int MATRICES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [3:0] action,
	input  logic [2:0] matrix,
	input  logic [2:0] row,
	input  logic [7:0] row_data,
	input  logic       m_tready,
	input  dp_status_t status,
	output buf_cmd_t   buf_cmd,
	output emit_cmd_t  emit_cmd
);

	localparam int DEV_W = (MATRICES > 1) ? $clog2(MATRICES) : 1;
	localparam logic [DEV_W-1:0] DEV_FAR = DEV_W'(MATRICES - 1);

	state_t            state_q, state_d;
	kind_t             kind_q, kind_d;
	logic [XFER_W-1:0] xfer_q, xfer_end;
	logic [DEV_W-1:0]  dev_q;
	logic              accept, out_free, step, done;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !status.out_valid || m_tready;
	assign step     = (state_q == ST_EMIT) && out_free;

	always_comb begin
		case (kind_q)
			KIND_INIT:      xfer_end = XFER_INIT_END;
			KIND_INTENSITY: xfer_end = XFER_ONE_END;
			KIND_REFRESH:   xfer_end = XFER_ROWS_END;
			default:        xfer_end = XFER_ONE_END;
		endcase
	end

	assign done = (dev_q == '0) && (xfer_q == xfer_end);

	// decode of the accepted item
	always_comb begin
		kind_d = kind_q;
		case (action)
			ACT_INIT:      kind_d = KIND_INIT;
			ACT_INTENSITY: kind_d = KIND_INTENSITY;
			ACT_REFRESH:   kind_d = KIND_REFRESH;
			default:       kind_d = kind_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (action == ACT_INIT || action == ACT_INTENSITY ||
						action == ACT_REFRESH)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (step && done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready        = 1'b0;
		buf_cmd.op      = BUF_NONE;
		buf_cmd.matrix  = matrix;
		buf_cmd.row     = row;
		buf_cmd.data    = row_data;
		emit_cmd.load   = 1'b0;
		emit_cmd.kind   = kind_q;
		emit_cmd.xfer   = xfer_q;
		emit_cmd.device = DEVICE_W'(dev_q);
		emit_cmd.last   = done;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (action)
						ACT_WRITE: buf_cmd.op = BUF_WRITE;
						ACT_SHL:   buf_cmd.op = BUF_SHL;
						ACT_SHR:   buf_cmd.op = BUF_SHR;
						ACT_ROL:   buf_cmd.op = BUF_ROL;
						ACT_ROR:   buf_cmd.op = BUF_ROR;
						ACT_CLEAR: buf_cmd.op = BUF_CLEAR;
						ACT_FILL:  buf_cmd.op = BUF_FILL;
						default:   buf_cmd.op = BUF_NONE;
					endcase
				end
			end
			ST_EMIT: begin
				emit_cmd.load = out_free;
			end
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_INIT;
			xfer_q  <= '0;
			dev_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				kind_q <= kind_d;
				xfer_q <= '0;
				dev_q  <= DEV_FAR;
			end else if (step) begin
				if (dev_q == '0) begin
					dev_q  <= DEV_FAR;
					xfer_q <= xfer_q + 1'b1;
				end else begin
					dev_q <= dev_q - 1'b1;
				end
			end
		end
	end

	a_load_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_cmd.load |-> state_q == ST_EMIT)
		else $error("frame loaded outside emit state");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_cmd.load && emit_cmd.last) |=> state_q == ST_IDLE)
		else $error("sequencer kept running after last frame");

	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> dev_q <= DEV_FAR)
		else $error("device counter out of range");

	a_xfer_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> xfer_q <= xfer_end)
		else $error("transfer counter past end");

	a_no_edit_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		buf_cmd.op != BUF_NONE |-> state_q == ST_IDLE)
		else $error("buffer edited during emission");

endmodule

FILE: hw/rtl/lmsr_datapath.sv
// ----------------------------------------------------------------------------
// lmsr_datapath
// Frame buffer rows, brightness register, frame build and output register.
// ----------------------------------------------------------------------------
module lmsr_datapath import lmsr_pkg::*; #(
	parameter int MATRICES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                brightness_we,
	input  logic [3:0]          brightness_wdata,
	input  buf_cmd_t            buf_cmd,
	input  emit_cmd_t           emit_cmd,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [3:0]          reg_addr,
	output logic [7:0]          reg_data,
	output logic [DEVICE_W-1:0] device,
	output logic                end_of_transfer,
	output logic                last,
	output dp_status_t          status
);

	localparam int WORD_W = 8 * MATRICES;

	// one wide word per row across the chain, matrix 0 in the low byte
	logic [WORD_W-1:0] rows_q [ROWS];
	logic [3:0]        bright_q;
	logic              valid_q;
	logic [3:0]        addr_d;
	logic [7:0]        data_d;
	logic [WORD_W-1:0] sel_word;
	logic [7:0]        sel_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_RESET;
		end else if (brightness_we) begin
			bright_q <= brightness_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				rows_q[r] <= '0;
			end
		end else begin
			case (buf_cmd.op)
				BUF_WRITE: begin
					for (int m = 0; m < MATRICES; m++) begin
						if ({1'b0, buf_cmd.matrix} == 4'(m)) begin
							rows_q[buf_cmd.row][m*8 +: 8] <= buf_cmd.data;
						end
					end
				end
				BUF_SHL: begin
					for (int r = 0; r < ROWS; r++) begin
						rows_q[r] <= {1'b0, rows_q[r][WORD_W-1:1]};
					end
				end
				BUF_ROL: begin
					for (int r = 0; r < ROWS; r++) begin
						rows_q[r] <= {rows_q[r][0], rows_q[r][WORD_W-1:1]};
					end
				end
				BUF_SHR: begin
					for (int r = 0; r < ROWS; r++) begin
						rows_q[r] <= {rows_q[r][WORD_W-2:0], 1'b0};
					end
				end
				BUF_ROR: begin
					for (int r = 0; r < ROWS; r++) begin
						rows_q[r] <= {rows_q[r][WORD_W-2:0], rows_q[r][WORD_W-1]};
					end
				end
				BUF_CLEAR: begin
					for (int r = 0; r < ROWS; r++) begin
						rows_q[r] <= '0;
					end
				end
				BUF_FILL: begin
					for (int r = 0; r < ROWS; r++) begin
						rows_q[r] <= {MATRICES{BYTE_FULL}};
					end
				end
				default: ;
			endcase
		end
	end

	assign sel_word = rows_q[emit_cmd.xfer];

	always_comb begin
		sel_byte = '0;
		for (int m = 0; m < MATRICES; m++) begin
			if ({1'b0, emit_cmd.device} == 4'(m)) begin
				sel_byte = sel_word[m*8 +: 8];
			end
		end
	end

	always_comb begin
		addr_d = ADDR_INTENSITY;
		data_d = {4'd0, bright_q};
		case (emit_cmd.kind)
			KIND_INIT: begin
				case (emit_cmd.xfer)
					XFER_SHUTDOWN: begin
						addr_d = ADDR_SHUTDOWN;
						data_d = 8'd0;
					end
					XFER_DECODE: begin
						addr_d = ADDR_DECODE;
						data_d = 8'd0;
					end
					XFER_SCAN: begin
						addr_d = ADDR_SCAN;
						data_d = SCAN_ALL_ROWS;
					end
					XFER_WAKE: begin
						addr_d = ADDR_SHUTDOWN;
						data_d = 8'd1;
					end
					default: ;
				endcase
			end
			KIND_INTENSITY: ;
			KIND_REFRESH: begin
				addr_d = {1'b0, emit_cmd.xfer} + 4'd1;
				data_d = sel_byte;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_cmd.load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_cmd.load) begin
			reg_addr        <= addr_d;
			reg_data        <= data_d;
			device          <= emit_cmd.device;
			end_of_transfer <= (emit_cmd.device == '0);
			last            <= emit_cmd.last;
		end
	end

	assign m_tvalid         = valid_q;
	assign status.out_valid = valid_q;

endmodule

FILE: hw/rtl/led_matrix_scroll_refresh_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_scroll_refresh_unit
// Frame buffer and register-frame generator for a chain of 8x8 LED matrices.
// ----------------------------------------------------------------------------
// Buffer commands (write row, shifts, rotates, clear, fill) are applied as
// they are accepted and the next item can follow in the cycle after. Init
// gives 5*MATRICES frames, set intensity MATRICES frames and refresh
// 8*MATRICES frames; the sequencer loads one frame per cycle into the output
// register while the sink is ready, and input is held off until the last
// frame of such a command has been loaded. The buffer sits in flip-flops and
// is blank straight out of reset.
module led_matrix_scroll_refresh_unit import lmsr_pkg::*; #(
	parameter int MATRICES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        brightness_we,
	input  logic [3:0]  brightness_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // matrix[2:0], row[5:3], row_data[13:6], zero[15:14]
	input  logic [3:0]  s_tuser,  // action[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // reg_addr[3:0], reg_data[11:4], device[14:12], zero[15]
	output logic        m_tuser,  // end_of_transfer[0]
	output logic        m_tlast
);

	buf_cmd_t            buf_cmd;
	emit_cmd_t           emit_cmd;
	dp_status_t          status;
	logic [3:0]          reg_addr;
	logic [7:0]          reg_data;
	logic [DEVICE_W-1:0] device;

	lmsr_ctrl #(
		.MATRICES (MATRICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.matrix   (s_tdata[2:0]),
		.row      (s_tdata[5:3]),
		.row_data (s_tdata[13:6]),
		.m_tready (m_tready),
		.status   (status),
		.buf_cmd  (buf_cmd),
		.emit_cmd (emit_cmd)
	);

	lmsr_datapath #(
		.MATRICES (MATRICES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.brightness_we    (brightness_we),
		.brightness_wdata (brightness_wdata),
		.buf_cmd          (buf_cmd),
		.emit_cmd         (emit_cmd),
		.m_tready         (m_tready),
		.m_tvalid         (m_tvalid),
		.reg_addr         (reg_addr),
		.reg_data         (reg_data),
		.device           (device),
		.end_of_transfer  (m_tuser),
		.last             (m_tlast),
		.status           (status)
	);

	assign m_tdata = {1'b0, device, reg_data, reg_addr};

endmodule
